// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the probe search RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/tnps_pkg.sv -----
// ----------------------------------------------------------------------------
// tnps_pkg
// Widths, constants and types shared by the two-nearest probe search.
// ----------------------------------------------------------------------------
package tnps_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int COORD_W   = 24;
  localparam int NORM_W    = 16;
  localparam int OFFS_W    = 24;
  localparam int SLOT_W    = 6;
  localparam int IDX_OUT_W = 7;
  localparam int CNT_REG_W = 7;

  localparam int ENTRY_W    = 3 * COORD_W;
  localparam int DELTA_W    = COORD_W + 1;
  localparam int SQ_W       = 2 * DELTA_W;
  localparam int DIST_W     = SQ_W + 2;
  localparam int NPROD_W    = COORD_W + NORM_W;
  localparam int PLANE_W    = NPROD_W + 4;
  localparam int NORM_SHIFT = 14;

  // Squared distance limit, (99999 * 16)^2 in 1/256 square units.
  localparam logic [DIST_W-1:0] DIST_LIMIT_SQ = 52'd2559948800256;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } tnps_state_t;

endpackage

// ----- sv/tnps_tracker.sv -----
// ----------------------------------------------------------------------------
// tnps_tracker
// Running nearest / second-nearest tracker, one probe distance per step cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tnps_tracker
  import tnps_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        clear,
  input  logic                                        step,
  input  logic                                        front,
  input  logic [DIST_W-1:0]                           sq_dist,
  input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] idx,
  output logic                                        found,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] nearest,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] second
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic              have1_r, have2_r;
  logic [DIST_W-1:0] d1_r, d2_r;
  logic [AW-1:0]     r1_r, r2_r;
  logic              lt1, lt2, take1, shift2;

  assign lt1    = sq_dist < d1_r;
  assign lt2    = sq_dist < d2_r;
  assign take1  = front && lt1;
  // A displaced nearest drops to second only when it beats the current second.
  assign shift2 = have1_r && (d1_r < d2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have1_r <= 1'b0;
      have2_r <= 1'b0;
    end else if (clear) begin
      have1_r <= 1'b0;
      have2_r <= 1'b0;
    end else if (step) begin
      if (take1) begin
        have1_r <= 1'b1;
        if (shift2) begin
          have2_r <= 1'b1;
        end
      end else if (lt2) begin
        have2_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      d1_r <= DIST_LIMIT_SQ;
      d2_r <= DIST_LIMIT_SQ;
    end else if (step) begin
      if (take1) begin
        if (shift2) begin
          d2_r <= d1_r;
          r2_r <= r1_r;
        end
        d1_r <= sq_dist;
        r1_r <= idx;
      end else if (lt2) begin
        d2_r <= sq_dist;
        r2_r <= idx;
      end
    end
  end

  assign found   = have1_r;
  assign nearest = r1_r;
  assign second  = have2_r ? r2_r : r1_r;

  `ASSERT_IMP(a_near_in_limit, clk, rst_n, have1_r, d1_r < DIST_LIMIT_SQ)
  `ASSERT_IMP(a_second_in_limit, clk, rst_n, have2_r, d2_r < DIST_LIMIT_SQ)
  `ASSERT_NEXT(a_clear_empties, clk, rst_n, clear, !have1_r && !have2_r)

endmodule

// ----- sv/two_nearest_probe_search_core.sv -----
// ----------------------------------------------------------------------------
// two_nearest_probe_search_core
// Probe origin table with a front-filtered two-nearest search per query.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries load and query transactions (valid/stall). A load
// writes one probe origin into the table in the cycle it is accepted and
// gives no result. A query scans entries 0 .. N-1, N being entry_count limited
// to MAX_ENTRIES, reading one entry per cycle through the one read port of the
// origin memory; that port sets the pace. Each query gives one result
// transaction on the output channel (valid/stall).
// A query result is loaded into the output register in the done state, once
// all N reads are issued and the pipeline has drained; the next transaction
// can be accepted in the cycle after. A load leaves the block idle.
// A held result does not block new transactions; only a finished query that
// finds the output register still stalled waits for it.
// The cfg channel writes entry_count and is always ready; write it only
// while the block is idle. Reset clears entry_count and all control state;
// table contents are undefined until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_nearest_probe_search_core
  import tnps_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [SLOT_W-1:0]           in_entry_index,
  input  logic signed [COORD_W-1:0]   in_coord_x,
  input  logic signed [COORD_W-1:0]   in_coord_y,
  input  logic signed [COORD_W-1:0]   in_coord_z,
  input  logic signed [NORM_W-1:0]    in_plane_nx,
  input  logic signed [NORM_W-1:0]    in_plane_ny,
  input  logic signed [NORM_W-1:0]    in_plane_nz,
  input  logic signed [OFFS_W-1:0]    in_plane_offset,
  input  logic                        in_plane_back,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [IDX_OUT_W-1:0]        out_nearest_index,
  output logic [IDX_OUT_W-1:0]        out_second_index,
  output logic                        out_used_fallback,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CNT_REG_W-1:0]        cfg_entry_count
);

  localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W0 = $clog2(MAX_ENTRIES + 1);
  localparam int CW     = (CNT_W0 > IDX_OUT_W) ? CNT_W0 : IDX_OUT_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  tnps_state_t state_r, state_nxt;

  logic [CNT_REG_W-1:0] cfg_count_r;

  logic                       in_acc, load_acc, query_acc;
  logic [CW-1:0]              slot_w, count_sel;
  logic                       wr_en, issue, pipe_busy, scan_end, out_free;

  // Query operands.
  logic signed [COORD_W-1:0]  px_r, py_r, pz_r;
  logic signed [NORM_W-1:0]   nx_r, ny_r, nz_r;
  logic signed [OFFS_W-1:0]   off_r;
  logic                       back_r;
  logic [CW-1:0]              cnt_r, rd_idx_r;

  // Origin memory.
  logic [ENTRY_W-1:0]         mem [MAX_ENTRIES];
  logic [ENTRY_W-1:0]         rd_data_r;

  // Scan pipeline.
  logic                       v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0]              i1_r, i2_r, i3_r, i4_r;
  logic signed [COORD_W-1:0]  ox_w, oy_w, oz_w;
  logic signed [DELTA_W-1:0]  dx_r, dy_r, dz_r;
  logic signed [COORD_W-1:0]  ox_r, oy_r, oz_r;
  logic signed [SQ_W-1:0]     sqx_w, sqy_w, sqz_w;
  logic signed [NPROD_W-1:0]  pnx_w, pny_w, pnz_w;
  logic [SQ_W-1:0]            sqx_r, sqy_r, sqz_r;
  logic signed [NPROD_W-1:0]  pnx_r, pny_r, pnz_r;
  logic signed [PLANE_W-1:0]  plane_w;
  logic                       front_w;
  logic [DIST_W-1:0]          dist_r;
  logic                       front_r;

  // Tracker outputs.
  logic                       ft_found, fb_found;
  logic [AW-1:0]              ft_near, ft_sec, fb_near, fb_sec;

  // Result selection and output register.
  logic [CW-1:0]              res_near, res_sec;
  logic                       res_fb;
  logic                       out_valid_r, out_fb_r;
  logic [IDX_OUT_W-1:0]       out_near_r, out_sec_r;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (in_mode == MODE_LOAD);
  assign query_acc = in_acc && (in_mode == MODE_QUERY);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_count_r <= cfg_entry_count;
    end
  end

  assign slot_w    = CW'(in_entry_index);
  assign wr_en     = load_acc && (slot_w < MAX_CNT);
  assign count_sel = (CW'(cfg_count_r) > MAX_CNT) ? MAX_CNT : CW'(cfg_count_r);

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  assign issue     = (state_r == ST_SCAN) && (rd_idx_r < cnt_r);
  assign pipe_busy = v1_r || v2_r || v3_r || v4_r;
  assign scan_end  = (state_r == ST_SCAN) && !issue && !pipe_busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (query_acc) begin
        rd_idx_r <= '0;
        cnt_r    <= count_sel;
      end else if (issue) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      px_r   <= in_coord_x;
      py_r   <= in_coord_y;
      pz_r   <= in_coord_z;
      nx_r   <= in_plane_nx;
      ny_r   <= in_plane_ny;
      nz_r   <= in_plane_nz;
      off_r  <= in_plane_offset;
      back_r <= in_plane_back;
    end
  end

  // --------------------------------------------------------------------------
  // Origin memory: one write port for loads, one registered read for scans.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_w[AW-1:0]] <= {in_coord_z, in_coord_y, in_coord_x};
    end
    if (issue) begin
      rd_data_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Scan pipeline: deltas, products, sums, then the trackers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign ox_w = $signed(rd_data_r[COORD_W-1:0]);
  assign oy_w = $signed(rd_data_r[2*COORD_W-1:COORD_W]);
  assign oz_w = $signed(rd_data_r[3*COORD_W-1:2*COORD_W]);

  assign sqx_w = dx_r * dx_r;
  assign sqy_w = dy_r * dy_r;
  assign sqz_w = dz_r * dz_r;
  assign pnx_w = ox_r * nx_r;
  assign pny_w = oy_r * ny_r;
  assign pnz_w = oz_r * nz_r;

  assign plane_w = PLANE_W'(pnx_r) + PLANE_W'(pny_r) + PLANE_W'(pnz_r)
                 - (PLANE_W'(off_r) <<< NORM_SHIFT);
  // With the back flag the test is mirrored, so a zero result is in front
  // on both sides.
  assign front_w = back_r ? (plane_w[PLANE_W-1] || (plane_w == '0))
                          : !plane_w[PLANE_W-1];

  always_ff @(posedge clk) begin
    i1_r <= rd_idx_r[AW-1:0];
    i2_r <= i1_r;
    i3_r <= i2_r;
    i4_r <= i3_r;

    dx_r <= DELTA_W'(ox_w) - DELTA_W'(px_r);
    dy_r <= DELTA_W'(oy_w) - DELTA_W'(py_r);
    dz_r <= DELTA_W'(oz_w) - DELTA_W'(pz_r);
    ox_r <= ox_w;
    oy_r <= oy_w;
    oz_r <= oz_w;

    sqx_r <= $unsigned(sqx_w);
    sqy_r <= $unsigned(sqy_w);
    sqz_r <= $unsigned(sqz_w);
    pnx_r <= pnx_w;
    pny_r <= pny_w;
    pnz_r <= pnz_w;

    dist_r  <= DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);
    front_r <= front_w;
  end

  tnps_tracker #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front_trk (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (query_acc),
    .step    (v4_r),
    .front   (front_r),
    .sq_dist (dist_r),
    .idx     (i4_r),
    .found   (ft_found),
    .nearest (ft_near),
    .second  (ft_sec)
  );

  // Plain two-nearest search over all probes, used when none is in front.
  tnps_tracker #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_fallback_trk (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (query_acc),
    .step    (v4_r),
    .front   (1'b1),
    .sq_dist (dist_r),
    .idx     (i4_r),
    .found   (fb_found),
    .nearest (fb_near),
    .second  (fb_sec)
  );

  // --------------------------------------------------------------------------
  // Result selection and output register
  // --------------------------------------------------------------------------
  always_comb begin
    if (ft_found) begin
      res_near = CW'(ft_near);
      res_sec  = CW'(ft_sec);
      res_fb   = 1'b0;
    end else if (fb_found) begin
      res_near = CW'(fb_near);
      res_sec  = CW'(fb_sec);
      res_fb   = 1'b1;
    end else begin
      res_near = MAX_CNT;
      res_sec  = MAX_CNT;
      res_fb   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_near_r <= res_near[IDX_OUT_W-1:0];
      out_sec_r  <= res_sec[IDX_OUT_W-1:0];
      out_fb_r   <= res_fb;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_near_r;
  assign out_second_index  = out_sec_r;
  assign out_used_fallback = out_fb_r;

  `ASSERT_IMP(a_scan_bound, clk, rst_n, state_r == ST_SCAN, rd_idx_r <= cnt_r)
  `ASSERT_IMP(a_idle_pipe_empty, clk, rst_n, state_r == ST_IDLE, !pipe_busy)
  `ASSERT_IMP(a_front_has_probe, clk, rst_n, (state_r == ST_DONE) && !res_fb, res_near != MAX_CNT)
  `ASSERT_IMP(a_default_pair, clk, rst_n, state_r == ST_DONE, (res_near == MAX_CNT) == (res_sec == MAX_CNT))
  `ASSERT_NEXT(a_done_delivers, clk, rst_n, (state_r == ST_DONE) && out_free, out_valid_r && (state_r == ST_IDLE))

endmodule
